### rtl/bpc_pkg.sv
// shared types and constants for the button press classifier
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  localparam int TimeW  = 32;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_DOUBLE   = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_SHORT  = 2'd1,
    CLS_LONG   = 2'd2,
    CLS_DOUBLE = 2'd3
  } press_class_t;

  typedef struct packed {
    logic             prev_level;
    logic [TimeW-1:0] change_time;
    logic [TimeW-1:0] press_start;
    logic [TimeW-1:0] release_time;
    logic             held;
    logic             double_armed;
    press_class_t     cur_class;
  } bpc_state_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] double_press_ms;
  } bpc_cfg_t;

  localparam bpc_state_t StateReset = '{
    prev_level:   1'b1,
    change_time:  '0,
    press_start:  '0,
    release_time: '0,
    held:         1'b0,
    double_armed: 1'b0,
    cur_class:    CLS_NONE
  };

  localparam bpc_cfg_t CfgReset = '{
    debounce_ms:     16'd50,
    long_press_ms:   16'd1000,
    double_press_ms: 16'd300
  };

endpackage

`default_nettype wire

### rtl/bpc_classify.sv
// next-state logic: debounce, press timing and class update for one sample
`timescale 1ns / 1ps
`default_nettype none

module bpc_classify (
  input  wire logic                      level,
  input  wire logic [bpc_pkg::TimeW-1:0] now_ms,
  input  wire bpc_pkg::bpc_cfg_t         cfg,
  input  wire bpc_pkg::bpc_state_t       st,
  output bpc_pkg::bpc_state_t            st_nxt
);
  import bpc_pkg::*;

  logic [TimeW-1:0] chg_time;
  logic [TimeW-1:0] since_chg;
  logic [TimeW-1:0] since_press;
  logic [TimeW-1:0] since_rel;
  logic             stable;
  logic             rel_set;
  bpc_state_t       s;

  assign chg_time    = (level != st.prev_level) ? now_ms : st.change_time;
  assign since_chg   = now_ms - chg_time;
  assign since_press = now_ms - st.press_start;
  assign since_rel   = now_ms - st.release_time;
  assign stable      = since_chg > {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms};

  always_comb begin
    s             = st;
    s.prev_level  = level;
    s.change_time = chg_time;
    rel_set       = 1'b0;
    if (stable) begin
      if (!level) begin
        if (!st.held) begin
          s.press_start = now_ms;
          s.held        = 1'b1;
          s.cur_class   = CLS_NONE;
        end else if (since_press > {{(TimeW-CfgW){1'b0}}, cfg.long_press_ms} &&
                     st.cur_class == CLS_NONE) begin
          s.cur_class = CLS_LONG;
        end
      end else if (st.held) begin
        if (st.cur_class == CLS_NONE) begin
          if (st.double_armed &&
              since_rel < {{(TimeW-CfgW){1'b0}}, cfg.double_press_ms}) begin
            s.cur_class    = CLS_DOUBLE;
            s.double_armed = 1'b0;
          end else begin
            s.cur_class    = CLS_SHORT;
            s.release_time = now_ms;
            s.double_armed = 1'b1;
            rel_set        = 1'b1;
          end
        end
        s.held = 1'b0;
      end
    end
    // a release stamped this sample has zero age, so it cannot expire yet
    if (s.double_armed && !rel_set &&
        since_rel > {{(TimeW-CfgW){1'b0}}, cfg.double_press_ms}) begin
      s.double_armed = 1'b0;
    end
    st_nxt = s;
  end

endmodule

`default_nettype wire

### rtl/button_press_classifier_core.sv
// top level: config registers, classifier state and result register
// the class of an accepted request is registered when it is accepted and is on the output from the next cycle
// throughput: one request per cycle unless a result is stalled, the state update is a single pass through bpc_classify
// in_ready stays high unless a result is waiting and out_ready is low
// reset (rst_n low, synchronous): state to released / none, config to 50 / 1000 / 300 ms
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic                        in_switch_level,
  input  wire logic [bpc_pkg::TimeW-1:0]   in_now_ms,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [1:0]                  out_press_class,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [bpc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [bpc_pkg::CfgW-1:0]    cfg_data
);
  import bpc_pkg::*;

  bpc_cfg_t   cfg_r;
  bpc_state_t st_r;
  bpc_state_t st_nxt;
  logic       out_valid_r;
  logic [1:0] out_class_r;
  logic       in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_press_class = out_class_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: cfg_r.debounce_ms     <= cfg_data;
        CFG_LONG:     cfg_r.long_press_ms   <= cfg_data;
        CFG_DOUBLE:   cfg_r.double_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  bpc_classify u_classify (
    .level  (in_switch_level),
    .now_ms (in_now_ms),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= StateReset;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_class_r <= st_nxt.cur_class;
    end
  end

endmodule

`default_nettype wire

### rtl/bpc_checker.sv
// port-level checks for the button press classifier, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bpc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_press_class
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every accepted request yields a result next cycle
  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // a waiting result blocks new requests
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  // a stalled result holds its class
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_press_class))
    else $error("stalled result changed");

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (.*);

`default_nettype wire

### tb/sv/tb_button_press_classifier_core.sv
// testbench for the button press classifier core, self-checking against its own class predictor
`timescale 1ns / 1ps

module tb_button_press_classifier_core;
  import bpc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 200;
  localparam int NumPhases  = 7;

  class press_class_predictor;
    bpc_state_t   st;
    bpc_cfg_t     regs;
    press_class_t expected_classes[$];
    int           mismatches;

    function new();
      st = StateReset;
      regs = CfgReset;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_DEBOUNCE: regs.debounce_ms = data;
        CFG_LONG:     regs.long_press_ms = data;
        CFG_DOUBLE:   regs.double_press_ms = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic level, logic [TimeW-1:0] now);
      logic [TimeW-1:0] stable_for;
      logic [TimeW-1:0] held_for;
      logic [TimeW-1:0] since_release;
      if (level != st.prev_level) st.change_time = now;
      stable_for = now - st.change_time;
      if (stable_for > regs.debounce_ms) begin
        if (!level) begin
          if (!st.held) begin
            st.press_start = now;
            st.held = 1'b1;
            st.cur_class = CLS_NONE;
          end else begin
            held_for = now - st.press_start;
            if (held_for > regs.long_press_ms && st.cur_class == CLS_NONE)
              st.cur_class = CLS_LONG;
          end
        end else if (st.held) begin
          since_release = now - st.release_time;
          // a press that already went long stays long and does not arm
          if (st.cur_class == CLS_NONE) begin
            if (st.double_armed && since_release < regs.double_press_ms) begin
              st.cur_class = CLS_DOUBLE;
              st.double_armed = 1'b0;
            end else begin
              st.cur_class = CLS_SHORT;
              st.release_time = now;
              st.double_armed = 1'b1;
            end
          end
          st.held = 1'b0;
        end
      end
      since_release = now - st.release_time;
      if (st.double_armed && since_release > regs.double_press_ms) st.double_armed = 1'b0;
      st.prev_level = level;
      expected_classes.push_back(st.cur_class);
    endfunction

    function void check_class(logic [1:0] got);
      press_class_t want;
      if (expected_classes.size() == 0) begin
        $display("%0t: press class %0d with no request pending", $time, got);
        mismatches++;
      end else begin
        want = expected_classes.pop_front();
        if (got !== want) begin
          $display("%0t: press_class mismatch, expected %0d actual %0d", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_switch_level = 1'b1;
  logic [TimeW-1:0]   in_now_ms = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_press_class;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  press_class_predictor predictor = new();
  logic [TimeW-1:0] now_cursor;
  int               sent_items = 0;
  bit               no_gaps = 1'b0;
  int               rx_stall = 0;
  int               cycles = 0;

  button_press_classifier_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_switch_level (in_switch_level),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_press_class (out_press_class),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check each accepted class, then stall a random number of cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        predictor.check_class(out_press_class);
        rx_stall = no_gaps ? 0 : $urandom_range(0, 5);
      end
      if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // leaves in_valid high after acceptance so back-to-back requests keep it up
  task automatic send_sample(logic level, logic [TimeW-1:0] now);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_switch_level <= level;
    in_now_ms <= now;
    do @(posedge clk); while (!in_ready);
    predictor.note_sample(level, now);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (predictor.expected_classes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(logic [CfgW-1:0] db, logic [CfgW-1:0] lp,
                              logic [CfgW-1:0] dp, bit with_unused);
    cfg_idx_t        idx [4];
    logic [CfgW-1:0] val [4];
    int              n;
    idx[0] = CFG_DEBOUNCE; val[0] = db;
    idx[1] = CFG_LONG;     val[1] = lp;
    idx[2] = CFG_DOUBLE;   val[2] = dp;
    idx[3] = CFG_UNUSED;   val[3] = CfgW'($urandom());
    n = with_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      predictor.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic bounce(logic first_level);
    int k;
    k = $urandom_range(0, 3);
    for (int i = 0; i < k; i++) begin
      now_cursor = now_cursor + $urandom_range(0, 3);
      send_sample((i % 2) ? ~first_level : first_level, now_cursor);
    end
  endtask

  task automatic steady_run(logic level, int span);
    int n;
    n = $urandom_range(2, 6);
    for (int i = 0; i < n; i++) begin
      now_cursor = now_cursor + span / n + $urandom_range(0, 2);
      send_sample(level, now_cursor);
    end
  endtask

  // one press and release with contact bounce; hold and idle spans sized to the windows
  task automatic press_gesture();
    int db, lp, dp, hold, idle;
    db = predictor.regs.debounce_ms;
    lp = predictor.regs.long_press_ms;
    dp = predictor.regs.double_press_ms;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: now_cursor = $urandom();
        1: now_cursor = now_cursor - $urandom_range(0, 200);
        default: now_cursor = now_cursor + $urandom_range(0, 3);
      endcase
      send_sample(1'($urandom_range(0, 1)), now_cursor);
    end
    hold = $urandom_range(0, 1) ? $urandom_range(0, db + lp / 2 + 4)
                                : $urandom_range(0, 2 * (db + lp) + 20);
    idle = $urandom_range(0, 2 * (db + dp) + 20);
    bounce(1'b0);
    steady_run(1'b0, hold);
    bounce(1'b1);
    steady_run(1'b1, idle);
  endtask

  logic             dir_level [24];
  logic [TimeW-1:0] dir_now [24];

  initial begin
    // long press then release, short press, double press, arm lapse, wrap and backwards time
    dir_level = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                  1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    dir_now = '{32'd0, 32'd100, 32'd151, 32'd1200, 32'd1300, 32'd1360,
                32'd1400, 32'd1460, 32'd1500, 32'd1560, 32'd1600, 32'd1660,
                32'd1700, 32'd1760, 32'd1800, 32'd1860, 32'd1900, 32'd1960,
                32'd2261, 32'hFFFF_FFF0, 32'h0000_0030, 32'hFFFF_FFFF,
                32'd0, 32'h8000_0000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 24; i++) send_sample(dir_level[i], dir_now[i]);
    now_cursor = $urandom();
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: program_regs('0, '0, '0, 1'b1);
          2: program_regs('1, '1, '1, 1'b0);
          3: program_regs(CfgW'($urandom_range(0, 20)), CfgW'($urandom_range(10, 200)),
                          CfgW'($urandom_range(10, 300)), 1'b0);
          4: program_regs(16'd0, CfgW'($urandom_range(0, 100)), 16'hFFFF, 1'b1);
          default: program_regs(CfgW'($urandom_range(0, 20)), CfgW'($urandom_range(0, 300)),
                                CfgW'($urandom_range(0, 400)), 1'b0);
        endcase
      end
      no_gaps = (phase == 3);
      while (sent_items < (phase + 1) * PhaseItems) press_gesture();
    end
    drain();
    if (predictor.mismatches == 0 && predictor.expected_classes.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
